/* rtl/mh3_pkg.sv */
package mh3_pkg;

    localparam int LEN_W = 31;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] SEED_RESET = 32'h9747_b28c;
    localparam logic [31:0] HASH_C1    = 32'hcc9e_2d51;
    localparam logic [31:0] HASH_C2    = 32'h1b87_3593;
    localparam logic [31:0] HASH_C3    = 32'he654_6b64;
    localparam logic [31:0] HASH_C4    = 32'h85eb_ca6b;
    localparam logic [31:0] HASH_C5    = 32'hc2b2_ae35;

    typedef struct packed {
        logic [31:0]      k;
        logic [LEN_W-1:0] len;
        logic             first;
        logic             last;
        logic             full;
        logic             mix;
    } item_t;

endpackage

/* rtl/mh3_front.sv */
module mh3_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [31:0]                 s_data_word,
    input  logic [2:0]                  s_byte_count,
    input  logic                        s_last_word,
    input  logic [mh3_pkg::LEN_W-1:0]   s_msg_length,
    output logic                        q_valid,
    input  logic                        q_ready,
    output mh3_pkg::item_t              q_item
);
    import mh3_pkg::*;

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    item_t            s1_item_next;
    logic             s2_valid_reg;
    item_t            s2_item_reg;
    item_t            s2_item_next;
    logic             in_msg_reg;
    logic [LEN_W-1:0] len_reg;

    logic             s1_ready;
    logic             s2_ready;
    logic             accept;
    logic             is_first;
    logic             is_tail;
    logic [31:0]      byte_mask;
    logic [31:0]      masked_word;
    logic [31:0]      rot15;

    assign s2_ready = !s2_valid_reg || q_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;
    assign accept   = s_valid && s_ready;
    assign is_first = !in_msg_reg;
    assign is_tail  = s_last_word && (s_byte_count < 3'd4);

    always_comb begin
        case (s_byte_count)
            3'd1:    byte_mask = 32'h0000_00ff;
            3'd2:    byte_mask = 32'h0000_ffff;
            3'd3:    byte_mask = 32'h00ff_ffff;
            default: byte_mask = 32'hffff_ffff;
        endcase
    end

    assign masked_word = is_tail ? (s_data_word & byte_mask) : s_data_word;

    always_comb begin
        s1_item_next.k     = masked_word * HASH_C1;
        s1_item_next.len   = is_first ? s_msg_length : len_reg;
        s1_item_next.first = is_first;
        s1_item_next.last  = s_last_word;
        s1_item_next.full  = !is_tail;
        s1_item_next.mix   = !is_tail || (s_byte_count != 3'd0);
    end

    assign rot15 = {s1_item_reg.k[16:0], s1_item_reg.k[31:17]};

    always_comb begin
        s2_item_next   = s1_item_reg;
        s2_item_next.k = rot15 * HASH_C2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            in_msg_reg   <= 1'b0;
            len_reg      <= '0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (accept) begin
                in_msg_reg <= !s_last_word;
                if (is_first) begin
                    len_reg <= s_msg_length;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s1_item_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign q_valid = s2_valid_reg;
    assign q_item  = s2_item_reg;

    a_last_ends_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_word) |=> !in_msg_reg)
        else $error("message not closed after last beat");

endmodule

/* rtl/mh3_queue.sv */
module mh3_queue #(
    parameter int DEPTH = mh3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  mh3_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mh3_pkg::item_t pop_item
);
    import mh3_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue overfilled");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count lost a pop");

endmodule

/* rtl/mh3_back.sv */
module mh3_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                q_valid,
    output logic                q_ready,
    input  mh3_pkg::item_t      q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_hash_value
);
    import mh3_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [31:0] seed_reg;
    logic [31:0] run_reg;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        m_valid_reg;
    logic [31:0] m_hash_value_reg;

    logic        take;
    logic        out_free;
    logic [31:0] len_ext;
    logic [31:0] h0;
    logic [31:0] h1;
    logic [31:0] rot13;
    logic [31:0] h2;
    logic [31:0] fx;
    logic [31:0] mix13;
    logic [31:0] fin_v;
    logic [31:0] fin_out;

    assign q_ready  = (state_reg == ST_RUN);
    assign take     = q_valid && q_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign len_ext = {1'b0, q_item.len};
    assign h0      = q_item.first ? (seed_reg ^ len_ext) : run_reg;
    assign h1      = q_item.mix ? (h0 ^ q_item.k) : h0;
    assign rot13   = {h1[18:0], h1[31:19]};
    assign h2      = q_item.full ? (rot13 + {rot13[29:0], 2'b00} + HASH_C3) : h1;
    assign fx      = h2 ^ len_ext;
    assign mix13   = acc_reg ^ (acc_reg >> 13);
    assign fin_v   = acc_reg ^ (acc_reg >> 16);
    assign fin_out = (fin_v == '0) ? 32'd1 : fin_v;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (take && q_item.last) begin
                    state_next = ST_MUL1;
                    acc_next   = fx ^ (fx >> 16);
                end
            end
            ST_MUL1: begin
                state_next = ST_MUL2;
                acc_next   = acc_reg * HASH_C4;
            end
            ST_MUL2: begin
                state_next = ST_FIN;
                acc_next   = mix13 * HASH_C5;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            seed_reg    <= SEED_RESET;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            if (take && !q_item.last) begin
                run_reg <= h2;
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (state_reg == ST_FIN && out_free) begin
            m_hash_value_reg <= fin_out;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_value_reg;

    a_never_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_hash_value_reg != '0))
        else $error("zero hash presented");

    a_last_finalizes: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_item.last) |=> (state_reg == ST_MUL1))
        else $error("last beat did not start finalization");

    a_fin_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (m_valid_reg && state_reg == ST_RUN))
        else $error("finished hash not presented");

endmodule

/* rtl/murmur3_string_hash.sv */
// Channel  Ports                                            Accepted when
// input    s_data_word s_byte_count s_last_word s_msg_length s_valid && s_ready
// result   m_hash_value                                     m_valid && m_ready
// config   cfg_wr_data                                      cfg_wr_en
//
// The hash update loop folds in a full word (xor, rotate 13, times 5 plus C3) and sets
// the sustained rate of one word per cycle while no finalization holds it; the scramble
// runs ahead in a two-stage multiply pipeline and a QUEUE_DEPTH entry queue separates the two.
// A last word holds the update loop while it is finalized: load, two multiply steps, output.
// Reset is synchronous, active low, with no clearing pass; seed returns to 0x9747b28c.
// A stalled result holds the finalizer, the queue then fills and s_ready drops.
module murmur3_string_hash #(
    parameter int QUEUE_DEPTH = mh3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [31:0]                cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [31:0]                s_data_word,
    input  logic [2:0]                 s_byte_count,
    input  logic                       s_last_word,
    input  logic [mh3_pkg::LEN_W-1:0]  s_msg_length,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [31:0]                m_hash_value
);
    import mh3_pkg::*;

    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t back_item;
    logic  back_valid;
    logic  back_ready;

    mh3_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last_word  (s_last_word),
        .s_msg_length (s_msg_length),
        .q_valid      (front_valid),
        .q_ready      (front_ready),
        .q_item       (front_item)
    );

    mh3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    mh3_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_valid      (back_valid),
        .q_ready      (back_ready),
        .q_item       (back_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule
